// ===== rtl/core/hmc_leapfrog_gaussian_step_assert.svh =====
// Assertion macros for the HMC leapfrog block.
`ifndef HMC_LEAPFROG_GAUSSIAN_STEP_ASSERT_SVH
`define HMC_LEAPFROG_GAUSSIAN_STEP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define HMC_CHECK_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hmc_leapfrog_gaussian_step: check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define HMC_CHECK_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hmc_leapfrog_gaussian_step: check failed");

`endif

// ===== rtl/core/hmc_pkg.sv =====
`timescale 1ns / 1ps
// Types, constants and the micro-program of the HMC leapfrog block.
package hmc_pkg;

    localparam int FracBits = 24;
    localparam int DataW    = 32;
    localparam int HamW     = 48;

    typedef struct packed {
        logic signed [31:0] momentum_0;
        logic signed [31:0] momentum_1;
        logic signed [31:0] momentum_2;
        logic        [30:0] neg_log_uniform;
    } hmc_in_t;

    typedef struct packed {
        logic signed [31:0] position_0;
        logic signed [31:0] position_1;
        logic signed [31:0] position_2;
        logic               accepted;
        logic signed [47:0] ham_start;
        logic signed [47:0] ham_end;
        logic        [31:0] accept_total;
    } hmc_out_t;

    typedef enum logic [2:0] {
        CFG_COEF_00,
        CFG_COEF_11,
        CFG_COEF_22,
        CFG_COEF_01,
        CFG_COEF_02,
        CFG_COEF_12,
        CFG_STEP_SIZE,
        CFG_STEP_COUNT
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SCALE,
        ST_ACC,
        ST_DECIDE,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_START,
        PH_TRAJ,
        PH_END
    } phase_t;

    // Operand and destination registers of the shared unit.
    typedef enum logic [3:0] {
        REG_X0, REG_X1, REG_X2,
        REG_P0, REG_P1, REG_P2,
        REG_G, REG_T, REG_H,
        REG_C00, REG_C11, REG_C22, REG_C01, REG_C02, REG_C12,
        REG_STEP
    } reg_sel_t;

    typedef struct packed {
        logic signed [31:0] x0;
        logic signed [31:0] x1;
        logic signed [31:0] x2;
        logic signed [31:0] p0;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
        logic signed [31:0] g;
        logic signed [47:0] t;
        logic signed [47:0] h;
        logic signed [31:0] c00;
        logic signed [31:0] c11;
        logic signed [31:0] c22;
        logic signed [31:0] c01;
        logic signed [31:0] c02;
        logic signed [31:0] c12;
        logic        [30:0] step;
    } bank_t;

    // One micro-op: dst = sat(dst_or_zero +/- (mulq(a, b) / 2^half)).
    typedef struct packed {
        reg_sel_t src_a;
        reg_sel_t src_b;
        reg_sel_t dst;
        logic     wide;
        logic     half;
        logic     negate;
        logic     clear;
    } instr_t;

    localparam logic [5:0] PC_HAM_LAST    = 6'd14;
    localparam logic [5:0] PC_HALF_FIRST  = 6'd15;
    localparam logic [5:0] PC_HALF_LAST   = 6'd17;
    localparam logic [5:0] PC_KICK_FIRST  = 6'd18;
    localparam logic [5:0] PC_KICK_LAST   = 6'd29;
    localparam logic [5:0] PC_DRIFT_FIRST = 6'd30;
    localparam logic [5:0] PC_DRIFT_LAST  = 6'd32;

    function automatic instr_t mk(reg_sel_t a, reg_sel_t b, reg_sel_t d,
                                  logic w, logic hf, logic n, logic c);
        instr_t i;
        i.src_a  = a;
        i.src_b  = b;
        i.dst    = d;
        i.wide   = w;
        i.half   = hf;
        i.negate = n;
        i.clear  = c;
        return i;
    endfunction

    // Hamiltonian, half drift, kick and full drift sections in that order.
    function automatic instr_t program_rom(logic [5:0] pc);
        instr_t i;
        case (pc)
            6'd0:  i = mk(REG_X0,  REG_C00, REG_T, 1'b1, 1'b0, 1'b0, 1'b1);
            6'd1:  i = mk(REG_T,   REG_X0,  REG_H, 1'b1, 1'b1, 1'b0, 1'b1);
            6'd2:  i = mk(REG_X1,  REG_C01, REG_T, 1'b1, 1'b0, 1'b0, 1'b1);
            6'd3:  i = mk(REG_T,   REG_X0,  REG_H, 1'b1, 1'b0, 1'b0, 1'b0);
            6'd4:  i = mk(REG_X1,  REG_C11, REG_T, 1'b1, 1'b0, 1'b0, 1'b1);
            6'd5:  i = mk(REG_T,   REG_X1,  REG_H, 1'b1, 1'b1, 1'b0, 1'b0);
            6'd6:  i = mk(REG_X2,  REG_C02, REG_T, 1'b1, 1'b0, 1'b0, 1'b1);
            6'd7:  i = mk(REG_T,   REG_X0,  REG_H, 1'b1, 1'b0, 1'b0, 1'b0);
            6'd8:  i = mk(REG_X2,  REG_C12, REG_T, 1'b1, 1'b0, 1'b0, 1'b1);
            6'd9:  i = mk(REG_T,   REG_X1,  REG_H, 1'b1, 1'b0, 1'b0, 1'b0);
            6'd10: i = mk(REG_X2,  REG_C22, REG_T, 1'b1, 1'b0, 1'b0, 1'b1);
            6'd11: i = mk(REG_T,   REG_X2,  REG_H, 1'b1, 1'b1, 1'b0, 1'b0);
            6'd12: i = mk(REG_P0,  REG_P0,  REG_H, 1'b1, 1'b1, 1'b0, 1'b0);
            6'd13: i = mk(REG_P1,  REG_P1,  REG_H, 1'b1, 1'b1, 1'b0, 1'b0);
            6'd14: i = mk(REG_P2,  REG_P2,  REG_H, 1'b1, 1'b1, 1'b0, 1'b0);
            6'd15: i = mk(REG_P0,  REG_STEP, REG_X0, 1'b0, 1'b1, 1'b0, 1'b0);
            6'd16: i = mk(REG_P1,  REG_STEP, REG_X1, 1'b0, 1'b1, 1'b0, 1'b0);
            6'd17: i = mk(REG_P2,  REG_STEP, REG_X2, 1'b0, 1'b1, 1'b0, 1'b0);
            6'd18: i = mk(REG_C00, REG_X0,  REG_G, 1'b0, 1'b0, 1'b0, 1'b1);
            6'd19: i = mk(REG_C01, REG_X1,  REG_G, 1'b0, 1'b0, 1'b0, 1'b0);
            6'd20: i = mk(REG_C02, REG_X2,  REG_G, 1'b0, 1'b0, 1'b0, 1'b0);
            6'd21: i = mk(REG_G,   REG_STEP, REG_P0, 1'b0, 1'b0, 1'b1, 1'b0);
            6'd22: i = mk(REG_C01, REG_X0,  REG_G, 1'b0, 1'b0, 1'b0, 1'b1);
            6'd23: i = mk(REG_C11, REG_X1,  REG_G, 1'b0, 1'b0, 1'b0, 1'b0);
            6'd24: i = mk(REG_C12, REG_X2,  REG_G, 1'b0, 1'b0, 1'b0, 1'b0);
            6'd25: i = mk(REG_G,   REG_STEP, REG_P1, 1'b0, 1'b0, 1'b1, 1'b0);
            6'd26: i = mk(REG_C02, REG_X0,  REG_G, 1'b0, 1'b0, 1'b0, 1'b1);
            6'd27: i = mk(REG_C12, REG_X1,  REG_G, 1'b0, 1'b0, 1'b0, 1'b0);
            6'd28: i = mk(REG_C22, REG_X2,  REG_G, 1'b0, 1'b0, 1'b0, 1'b0);
            6'd29: i = mk(REG_G,   REG_STEP, REG_P2, 1'b0, 1'b0, 1'b1, 1'b0);
            6'd30: i = mk(REG_P0,  REG_STEP, REG_X0, 1'b0, 1'b0, 1'b0, 1'b0);
            6'd31: i = mk(REG_P1,  REG_STEP, REG_X1, 1'b0, 1'b0, 1'b0, 1'b0);
            6'd32: i = mk(REG_P2,  REG_STEP, REG_X2, 1'b0, 1'b0, 1'b0, 1'b0);
            default: i = mk(REG_X0, REG_X0, REG_X0, 1'b0, 1'b0, 1'b0, 1'b0);
        endcase
        return i;
    endfunction

    // Operand selection, extended to the Hamiltonian width (the step size with zeros, the rest with their sign).
    function automatic logic signed [47:0] pick(bank_t b, reg_sel_t s);
        logic signed [47:0] v;
        case (s)
            REG_X0:   v = {{16{b.x0[31]}}, b.x0};
            REG_X1:   v = {{16{b.x1[31]}}, b.x1};
            REG_X2:   v = {{16{b.x2[31]}}, b.x2};
            REG_P0:   v = {{16{b.p0[31]}}, b.p0};
            REG_P1:   v = {{16{b.p1[31]}}, b.p1};
            REG_P2:   v = {{16{b.p2[31]}}, b.p2};
            REG_G:    v = {{16{b.g[31]}}, b.g};
            REG_T:    v = b.t;
            REG_H:    v = b.h;
            REG_C00:  v = {{16{b.c00[31]}}, b.c00};
            REG_C11:  v = {{16{b.c11[31]}}, b.c11};
            REG_C22:  v = {{16{b.c22[31]}}, b.c22};
            REG_C01:  v = {{16{b.c01[31]}}, b.c01};
            REG_C02:  v = {{16{b.c02[31]}}, b.c02};
            REG_C12:  v = {{16{b.c12[31]}}, b.c12};
            REG_STEP: v = {17'd0, b.step};
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/hmc_leapfrog_gaussian_step.sv =====
`timescale 1ns / 1ps
// Top level of the HMC leapfrog block: sequencer, shared multiplier and chain state.
//
// This block performs one Hamiltonian Monte Carlo update of a three-dimensional chain
// per input transaction. The transaction carries three momenta and the threshold
// -ln(u); the block computes the starting Hamiltonian, runs a leapfrog trajectory of
// step_count steps (a count of zero behaves as one), computes the final Hamiltonian
// and accepts the move when ham_end - ham_start is below the threshold. All work goes
// through a single saturating Q8.24 multiply-accumulate unit whose 48x32 product is
// formed with one 24x32 multiplier in two passes, so every micro-op passes through
// the load, low multiply, high multiply, scale and accumulate states. The input stays
// stalled from acceptance until the result transaction has been taken. Configuration
// registers must only be written while the block is idle.
module hmc_leapfrog_gaussian_step (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  hmc_pkg::hmc_in_t       in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output hmc_pkg::hmc_out_t      out_data,
    input  logic                   cfg_we,
    input  hmc_pkg::cfg_index_t    cfg_index,
    input  logic [31:0]            cfg_data
);
    import hmc_pkg::*;

    state_t             state_reg, state_next;
    logic [5:0]         pc_reg;
    phase_t             phase_reg;
    logic [7:0]         rem_reg;
    logic [7:0]         steps_reg;
    bank_t              bank_reg;
    logic signed [47:0] h0_reg;
    logic [30:0]        thr_reg;
    logic signed [31:0] pos_reg [3];
    logic [31:0]        cnt_reg;
    logic               acc_reg;

    // Shared multiplier pipeline registers.
    logic [47:0]        ma_reg;
    logic [31:0]        mb_reg;
    logic               prod_neg_reg;
    logic [55:0]        plo_reg;
    logic [55:0]        phi_reg;
    logic [47:0]        mag_reg;

    instr_t             instr;
    logic signed [47:0] a_val, b_val, acc_val;
    logic [47:0]        a_mag;
    logic [31:0]        b_mag;
    logic [56:0]        mag_full;
    logic [47:0]        lim;
    logic [47:0]        mag_sat;
    logic signed [48:0] term;
    logic signed [49:0] sum, hi_lim, lo_lim;
    logic signed [47:0] res;
    logic signed [48:0] ham_diff;
    logic               accept_now;
    logic               last_op;

    assign instr   = program_rom(pc_reg);
    assign last_op = (pc_reg == PC_HAM_LAST) && (phase_reg == PH_END);

    // Operand fetch and magnitudes for the unsigned multiplier.
    always_comb
    begin
        a_val = pick(bank_reg, instr.src_a);
        b_val = pick(bank_reg, instr.src_b);
        a_mag = a_val[47] ? (~a_val + 48'd1) : a_val;
        b_mag = b_val[31] ? (~b_val[31:0] + 32'd1) : b_val[31:0];
    end

    // Rescale by the fraction bits and saturate the magnitude; halving is applied when it is registered.
    always_comb
    begin
        mag_full = {1'b0, phi_reg} + {25'd0, plo_reg[55:FracBits]};
        lim      = (instr.wide ? (48'd1 << (HamW - 1)) : (48'd1 << (DataW - 1)))
                 - {47'd0, ~prod_neg_reg};
        mag_sat  = (mag_full > {9'd0, lim}) ? lim : mag_full[47:0];
    end

    // Signed accumulate with saturation to the operation's width.
    always_comb
    begin
        term    = (prod_neg_reg ^ instr.negate) ? -$signed({1'b0, mag_reg})
                                                : $signed({1'b0, mag_reg});
        acc_val = instr.clear ? 48'sd0 : pick(bank_reg, instr.dst);
        sum     = 50'(acc_val) + 50'(term);
        hi_lim  = instr.wide ? ((50'sd1 <<< (HamW - 1)) - 50'sd1)
                             : ((50'sd1 <<< (DataW - 1)) - 50'sd1);
        lo_lim  = -hi_lim - 50'sd1;
        if (sum > hi_lim)
        begin
            res = hi_lim[47:0];
        end
        else if (sum < lo_lim)
        begin
            res = lo_lim[47:0];
        end
        else
        begin
            res = sum[47:0];
        end
    end

    // Metropolis test on the energy change.
    always_comb
    begin
        ham_diff   = 49'(bank_reg.h) - 49'(h0_reg);
        accept_now = ham_diff < $signed({18'd0, thr_reg});
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_LOAD;
            ST_LOAD:   state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_ACC;
            ST_ACC:    state_next = last_op ? ST_DECIDE : ST_LOAD;
            ST_DECIDE: state_next = ST_OUT;
            ST_OUT:    if (!out_stall) state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs of the sequencer.
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        out_valid = (state_reg == ST_OUT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Multiplier pipeline; the high and low halves of the first operand share one
    // 24x32 multiplier in consecutive cycles.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            ma_reg       <= a_mag;
            mb_reg       <= b_mag;
            prod_neg_reg <= a_val[47] ^ b_val[31];
        end
        if (state_reg == ST_MUL_LO)
        begin
            plo_reg <= ma_reg[23:0] * mb_reg;
        end
        if (state_reg == ST_MUL_HI)
        begin
            phi_reg <= ma_reg[47:24] * mb_reg;
        end
        if (state_reg == ST_SCALE)
        begin
            mag_reg <= instr.half ? (mag_sat >> 1) : mag_sat;
        end
    end

    // Working registers, configuration, program counter and chain state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg      <= '0;
            bank_reg.c00  <= 32'sd1 <<< FracBits;
            bank_reg.c11  <= 32'sd2 <<< FracBits;
            bank_reg.c22  <= 32'sd2 <<< FracBits;
            bank_reg.c01  <= 32'sd1 <<< FracBits;
            bank_reg.c02  <= 32'sd1 <<< FracBits;
            bank_reg.c12  <= 32'sd1 <<< FracBits;
            bank_reg.step <= 31'd1 << FracBits;
            steps_reg     <= 8'd40;
            pc_reg        <= '0;
            phase_reg     <= PH_START;
            rem_reg       <= '0;
            h0_reg        <= '0;
            thr_reg       <= '0;
            pos_reg[0]    <= '0;
            pos_reg[1]    <= '0;
            pos_reg[2]    <= '0;
            cnt_reg       <= '0;
            acc_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_COEF_00:    bank_reg.c00  <= cfg_data;
                    CFG_COEF_11:    bank_reg.c11  <= cfg_data;
                    CFG_COEF_22:    bank_reg.c22  <= cfg_data;
                    CFG_COEF_01:    bank_reg.c01  <= cfg_data;
                    CFG_COEF_02:    bank_reg.c02  <= cfg_data;
                    CFG_COEF_12:    bank_reg.c12  <= cfg_data;
                    CFG_STEP_SIZE:  bank_reg.step <= cfg_data[30:0];
                    CFG_STEP_COUNT: steps_reg     <= cfg_data[7:0];
                endcase
            end

            if (state_reg == ST_IDLE && in_valid)
            begin
                // A new transaction starts from the stored chain position.
                bank_reg.x0 <= pos_reg[0];
                bank_reg.x1 <= pos_reg[1];
                bank_reg.x2 <= pos_reg[2];
                bank_reg.p0 <= in_data.momentum_0;
                bank_reg.p1 <= in_data.momentum_1;
                bank_reg.p2 <= in_data.momentum_2;
                thr_reg     <= in_data.neg_log_uniform;
                pc_reg      <= '0;
                phase_reg   <= PH_START;
                rem_reg     <= (steps_reg == 8'd0) ? 8'd0 : (steps_reg - 8'd1);
            end

            if (state_reg == ST_ACC)
            begin
                case (instr.dst)
                    REG_X0:  bank_reg.x0 <= res[31:0];
                    REG_X1:  bank_reg.x1 <= res[31:0];
                    REG_X2:  bank_reg.x2 <= res[31:0];
                    REG_P0:  bank_reg.p0 <= res[31:0];
                    REG_P1:  bank_reg.p1 <= res[31:0];
                    REG_P2:  bank_reg.p2 <= res[31:0];
                    REG_G:   bank_reg.g  <= res[31:0];
                    REG_T:   bank_reg.t  <= res;
                    REG_H:   bank_reg.h  <= res;
                    default: ;
                endcase

                case (pc_reg)
                    PC_HAM_LAST:
                    begin
                        if (phase_reg == PH_START)
                        begin
                            h0_reg <= res;
                            pc_reg <= PC_HALF_FIRST;
                        end
                    end
                    PC_HALF_LAST:
                    begin
                        if (phase_reg == PH_START)
                        begin
                            phase_reg <= PH_TRAJ;
                            pc_reg    <= PC_KICK_FIRST;
                        end
                        else
                        begin
                            phase_reg <= PH_END;
                            pc_reg    <= '0;
                        end
                    end
                    PC_KICK_LAST:
                    begin
                        pc_reg <= (rem_reg != 8'd0) ? PC_DRIFT_FIRST : PC_HALF_FIRST;
                    end
                    PC_DRIFT_LAST:
                    begin
                        rem_reg <= rem_reg - 8'd1;
                        pc_reg  <= PC_KICK_FIRST;
                    end
                    default:
                    begin
                        pc_reg <= pc_reg + 6'd1;
                    end
                endcase
            end

            if (state_reg == ST_DECIDE)
            begin
                acc_reg <= accept_now;
                if (accept_now)
                begin
                    pos_reg[0] <= bank_reg.x0;
                    pos_reg[1] <= bank_reg.x1;
                    pos_reg[2] <= bank_reg.x2;
                    if (cnt_reg != '1)
                    begin
                        cnt_reg <= cnt_reg + 32'd1;
                    end
                end
            end
        end
    end

    // The result transaction is read straight from the held state.
    always_comb
    begin
        out_data.position_0   = pos_reg[0];
        out_data.position_1   = pos_reg[1];
        out_data.position_2   = pos_reg[2];
        out_data.accepted     = acc_reg;
        out_data.ham_start    = h0_reg;
        out_data.ham_end      = bank_reg.h;
        out_data.accept_total = cnt_reg;
    end

`include "hmc_leapfrog_gaussian_step_assert.svh"

    // The program counter never leaves the micro-program.
    `HMC_CHECK_IMPL(a_pc_in_program, 1'b1, pc_reg <= PC_DRIFT_LAST)
    // The accept counter only moves when a decision is taken.
    `HMC_CHECK_NEXT(a_cnt_only_on_decide, state_reg != ST_DECIDE, cnt_reg == $past(cnt_reg))
    // A rejected move leaves the chain position untouched (the first and third coordinates are checked).
    `HMC_CHECK_NEXT(a_reject_keeps_pos, state_reg == ST_DECIDE && !accept_now,
                    pos_reg[0] == $past(pos_reg[0]) && pos_reg[2] == $past(pos_reg[2]))

endmodule

// ===== verif/hmc_leapfrog_gaussian_step_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the HMC leapfrog block with a built-in leapfrog predictor.
module hmc_leapfrog_gaussian_step_tb;
    import hmc_pkg::*;

    // Cycles with no transaction on either channel and no configuration write before the
    // run is declared hung. The limit covers the slowest transaction (step count 255)
    // together with the long receiver hold-off.
    localparam int unsigned HangLimit = 100000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    hmc_in_t     in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    hmc_out_t    out_data;
    logic        cfg_we = 1'b0;
    cfg_index_t  cfg_index = CFG_COEF_00;
    logic [31:0] cfg_data = '0;

    hmc_leapfrog_gaussian_step dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Shadow copy of the block's configuration and chain state.
    longint      coef [3][3];
    longint      step_q;
    int          n_steps;
    longint      chain_pos [3];
    int unsigned accept_cnt;

    hmc_in_t     pending_q [$];   // momenta and thresholds not yet taken by the block
    hmc_out_t    update_q [$];    // predicted chain updates, oldest first
    int          errors = 0;
    int unsigned drv_cyc = 0;
    int unsigned mon_cyc = 0;
    int unsigned quiet_cyc = 0;

    // ------------------------------------------------------------------
    // Fixed-point arithmetic of the datapath.
    // ------------------------------------------------------------------

    function automatic longint clip(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // Exact product, magnitude truncated by the fraction bits, then saturated.
    function automatic longint mul_q(longint a, longint b, int w);
        logic         neg;
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] prod;
        logic [127:0] lim;
        neg  = (a < 0) != (b < 0);
        ua   = (a < 0) ? 64'(-a) : 64'(a);
        ub   = (b < 0) ? 64'(-b) : 64'(b);
        prod = {64'd0, ua} * {64'd0, ub};
        prod = prod >> FracBits;
        lim  = (128'd1 << (w - 1)) - (neg ? 128'd0 : 128'd1);
        if (prod > lim)
            prod = lim;
        return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function automatic longint energy(longint x [3], longint p [3]);
        longint h;
        longint t;
        h = 0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < i; j++)
            begin
                t = mul_q(x[i], coef[i][j], HamW);
                h = clip(h + mul_q(t, x[j], HamW), HamW);
            end
            t = mul_q(x[i], coef[i][i], HamW);
            h = clip(h + mul_q(t, x[i], HamW) / 2, HamW);
        end
        for (int i = 0; i < 3; i++)
            h = clip(h + mul_q(p[i], p[i], HamW) / 2, HamW);
        return h;
    endfunction

    // Momentum update from the gradient A*x.
    function automatic void kick(input longint x [3], inout longint p [3]);
        longint g;
        for (int i = 0; i < 3; i++)
        begin
            g = 0;
            for (int j = 0; j < 3; j++)
                g = clip(g + mul_q(coef[i][j], x[j], DataW), DataW);
            p[i] = clip(p[i] - mul_q(g, step_q, DataW), DataW);
        end
    endfunction

    // Position update; the half step halves the saturated product.
    function automatic void drift(inout longint x [3], input longint p [3], input bit half);
        longint d;
        for (int i = 0; i < 3; i++)
        begin
            d = mul_q(p[i], step_q, DataW);
            if (half)
                d = d / 2;
            x[i] = clip(x[i] + d, DataW);
        end
    endfunction

    // One full Metropolis-corrected update; advances the shadow chain state.
    function automatic hmc_out_t leapfrog_update(hmc_in_t it);
        hmc_out_t r;
        longint   x [3];
        longint   p [3];
        longint   h0;
        longint   h1;
        logic     acc;
        x    = chain_pos;
        p[0] = longint'($signed(it.momentum_0));
        p[1] = longint'($signed(it.momentum_1));
        p[2] = longint'($signed(it.momentum_2));
        h0 = energy(x, p);
        drift(x, p, 1'b1);
        // A step count of zero runs the same trajectory as a count of one.
        for (int s = 1; s < n_steps; s++)
        begin
            kick(x, p);
            drift(x, p, 1'b0);
        end
        kick(x, p);
        drift(x, p, 1'b1);
        h1  = energy(x, p);
        acc = (h1 - h0) < longint'({1'b0, it.neg_log_uniform});
        if (acc)
        begin
            for (int i = 0; i < 3; i++)
                chain_pos[i] = clip(x[i], 32);
            if (accept_cnt != 32'hFFFF_FFFF)
                accept_cnt++;
        end
        r.position_0   = chain_pos[0][31:0];
        r.position_1   = chain_pos[1][31:0];
        r.position_2   = chain_pos[2][31:0];
        r.accepted     = acc;
        r.ham_start    = h0[47:0];
        r.ham_end      = h1[47:0];
        r.accept_total = accept_cnt;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration writes, only issued while the block is idle.
    // ------------------------------------------------------------------

    task automatic set_reg(cfg_index_t idx, logic [31:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        case (idx)
            CFG_COEF_00:    coef[0][0] = longint'($signed(v));
            CFG_COEF_11:    coef[1][1] = longint'($signed(v));
            CFG_COEF_22:    coef[2][2] = longint'($signed(v));
            CFG_COEF_01:
            begin
                coef[0][1] = longint'($signed(v));
                coef[1][0] = coef[0][1];
            end
            CFG_COEF_02:
            begin
                coef[0][2] = longint'($signed(v));
                coef[2][0] = coef[0][2];
            end
            CFG_COEF_12:
            begin
                coef[1][2] = longint'($signed(v));
                coef[2][1] = coef[1][2];
            end
            CFG_STEP_SIZE:  step_q  = longint'(v[30:0]);
            CFG_STEP_COUNT: n_steps = int'(v[7:0]);
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(logic [31:0] c00, logic [31:0] c11, logic [31:0] c22,
                           logic [31:0] c01, logic [31:0] c02, logic [31:0] c12,
                           logic [31:0] stp, logic [31:0] cnt);
        set_reg(CFG_COEF_00, c00);
        set_reg(CFG_COEF_11, c11);
        set_reg(CFG_COEF_22, c22);
        set_reg(CFG_COEF_01, c01);
        set_reg(CFG_COEF_02, c02);
        set_reg(CFG_COEF_12, c12);
        set_reg(CFG_STEP_SIZE, stp);
        set_reg(CFG_STEP_COUNT, cnt);
    endtask

    // Waits until every queued transaction has gone through and its result has come back.
    // Every transaction yields exactly one result, so nothing is still in flight after that.
    task automatic drain();
        while (pending_q.size() != 0 || update_q.size() != 0 || in_valid)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic queue_item(logic [31:0] m0, logic [31:0] m1, logic [31:0] m2,
                              logic [30:0] thr);
        hmc_in_t it;
        it.momentum_0      = m0;
        it.momentum_1      = m1;
        it.momentum_2      = m2;
        it.neg_log_uniform = thr;
        pending_q.push_back(it);
    endtask

    function automatic logic [31:0] rnd_signed(int unsigned span);
        return $urandom_range(2 * span) - span;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers pending transactions, idling at random outside the calm window.
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            drv_cyc <= drv_cyc + 1;
            if (!(in_valid && in_stall))
            begin
                // The shadow state only advances when the block actually takes a transaction.
                if (in_valid)
                begin
                    update_q.push_back(leapfrog_update(in_data));
                    void'(pending_q.pop_front());
                end
                if (pending_q.size() != 0
                    && (drv_cyc > 200000 && drv_cyc < 300000 || $urandom_range(99) >= 35))
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_q[0];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result transaction against the oldest prediction.
    // ------------------------------------------------------------------

    task automatic check_field(string tag, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, tag, want, got);
        end
    endtask

    hmc_out_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            mon_cyc <= mon_cyc + 1;
            if (out_valid && !out_stall)
            begin
                if (update_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result: expected none, got %h", $time, out_data);
                end
                else
                begin
                    want = update_q.pop_front();
                    check_field("position_0", 64'(want.position_0), 64'(out_data.position_0));
                    check_field("position_1", 64'(want.position_1), 64'(out_data.position_1));
                    check_field("position_2", 64'(want.position_2), 64'(out_data.position_2));
                    check_field("accepted", 64'(want.accepted), 64'(out_data.accepted));
                    check_field("ham_start", 64'(want.ham_start), 64'(out_data.ham_start));
                    check_field("ham_end", 64'(want.ham_end), 64'(out_data.ham_end));
                    check_field("accept_total", 64'(want.accept_total),
                                64'(out_data.accept_total));
                end
            end
            // One long hold-off, placed in the random part where transactions are short,
            // lets the block sit on a finished result while the driver keeps offering;
            // outside it and the calm window, stall at random.
            if (mon_cyc >= 100000 && mon_cyc < 106000)
                out_stall <= 1'b1;
            else if (mon_cyc > 200000 && mon_cyc < 300000)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 35);
        end
    end

    // Watchdog on transaction progress.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cyc <= 0;
        else
            quiet_cyc <= quiet_cyc + 1;
        if (quiet_cyc >= HangLimit)
        begin
            $display("hmc_leapfrog_gaussian_step_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------

    initial
    begin
        logic [31:0] cmax;
        logic [31:0] cmin;
        cmax = 32'h7FFF_FFFF;
        cmin = 32'h8000_0000;

        // Shadow reset state: A = [[1,1,1],[1,2,1],[1,1,2]], step 1.0, 40 steps.
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
                coef[i][j] = longint'(1) << FracBits;
            chain_pos[i] = 0;
        end
        coef[1][1] = longint'(2) << FracBits;
        coef[2][2] = longint'(2) << FracBits;
        step_q     = longint'(1) << FracBits;
        n_steps    = 40;
        accept_cnt = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed, reset configuration: zero momenta against both threshold extremes,
        // then moderate and saturating momenta.
        queue_item(32'd0, 32'd0, 32'd0, 31'd0);
        queue_item(32'd0, 32'd0, 32'd0, 31'h7FFF_FFFF);
        queue_item(32'h0100_0000, 32'hFF00_0000, 32'h0080_0000, 31'h7FFF_FFFF);
        queue_item(cmax, cmin, cmax, 31'd0);
        queue_item(cmin, cmin, cmin, 31'h7FFF_FFFF);
        drain();

        // A step count of zero must behave as one.
        set_all(32'h0100_0000, 32'h0200_0000, 32'h0200_0000, 32'h0040_0000,
                32'hFFC0_0000, 32'h0020_0000, 32'h0040_0000, 32'd0);
        queue_item(32'h0180_0000, 32'hFE00_0000, 32'h0040_0000, 31'h0400_0000);
        queue_item(32'hFF00_0000, 32'h0100_0000, 32'h0100_0000, 31'd0);
        drain();

        // Extreme coefficients and step size: everything saturates.
        set_all(cmax, cmin, cmax, cmin, cmax, cmin, 32'h7FFF_FFFF, 32'd1);
        queue_item(cmax, cmax, cmin, 31'h7FFF_FFFF);
        queue_item(32'h0000_0001, 32'hFFFF_FFFF, 32'd0, 31'h5555_5555);
        queue_item(cmin, 32'h0100_0000, cmax, 31'd1);
        drain();

        // Zero step size leaves the trajectory in place.
        set_reg(CFG_STEP_SIZE, 32'd0);
        queue_item(32'h0200_0000, 32'hFE00_0000, 32'h0100_0000, 31'd1);
        drain();

        // Longest trajectory.
        set_all(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'd0, 32'd0, 32'd0,
                32'h0004_0000, 32'd255);
        queue_item(32'h0100_0000, 32'hFF00_0000, 32'h0080_0000, 31'h0100_0000);
        queue_item(32'hFF80_0000, 32'h0040_0000, 32'h0100_0000, 31'h0200_0000);
        drain();

        // Random part: short trajectories on well-conditioned matrices so that moves are
        // both taken and refused, with every fifth setting fully random.
        for (int ph = 0; ph < 15; ph++)
        begin
            if (ph % 5 == 4)
                set_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom_range(8));
            else
                set_all($urandom_range(32'h0400_0000, 32'h0080_0000),
                        $urandom_range(32'h0400_0000, 32'h0080_0000),
                        $urandom_range(32'h0400_0000, 32'h0080_0000),
                        rnd_signed(32'h0080_0000), rnd_signed(32'h0080_0000),
                        rnd_signed(32'h0080_0000),
                        $urandom_range(32'h0080_0000, 32'h0010_0000),
                        $urandom_range(6, 1));
            for (int k = 0; k < 100; k++)
            begin
                if ($urandom_range(99) < 80)
                    queue_item(rnd_signed(32'h0300_0000), rnd_signed(32'h0300_0000),
                               rnd_signed(32'h0300_0000),
                               31'($urandom_range(32'h0600_0000)));
                else
                    queue_item($urandom, $urandom, $urandom, 31'($urandom));
            end
            drain();
        end

        repeat (50) @(posedge clk);
        if (errors == 0 && update_q.size() == 0)
            $display("hmc_leapfrog_gaussian_step_tb: done, clean");
        else
            $display("hmc_leapfrog_gaussian_step_tb: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/hmc_pkg.sv
rtl/core/hmc_leapfrog_gaussian_step.sv
verif/hmc_leapfrog_gaussian_step_tb.sv
